// ===== rtl/core/sawarq_pkg.sv =====
// Shared constants and types for the stop-and-wait ARQ sender.
package sawarq_pkg;

  localparam int PACKET_BYTES = 64;
  localparam int FILL_W       = $clog2(PACKET_BYTES + 1);
  localparam int ADDR_W       = $clog2(PACKET_BYTES);
  localparam int IDX_W        = $clog2(PACKET_BYTES + 4);

  localparam logic [7:0] T_SEND  = 8'h20;
  localparam logic [7:0] T_ACK   = 8'h08;
  localparam logic [7:0] T_AGAIN = 8'h40;
  localparam logic [7:0] T_FIN   = 8'h10;

  localparam logic [7:0]  TIMEOUT_RST = 8'd20;
  localparam logic [11:0] ACK_LEN     = 12'd3;

  localparam logic [1:0] REQ_BYTE  = 2'd0;
  localparam logic [1:0] REQ_REPLY = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  localparam logic [2:0] ST_ACCEPTED = 3'd0;
  localparam logic [2:0] ST_SENT     = 3'd1;
  localparam logic [2:0] ST_TIMEOUT  = 3'd2;
  localparam logic [2:0] ST_NACK     = 3'd3;
  localparam logic [2:0] ST_FIN      = 3'd4;
  localparam logic [2:0] ST_REJECTED = 3'd5;

  typedef enum logic [1:0] {
    PH_COLLECT = 2'd0,
    PH_WAIT    = 2'd1,
    PH_DONE    = 2'd2
  } phase_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FETCH = 4'b0010,
    S_BYTE  = 4'b0100,
    S_PUSH  = 4'b1000
  } seq_state_t;

endpackage

// ===== rtl/core/stop_and_wait_arq_sender.sv =====
// Stop-and-wait ARQ sender: packet store, frame sequencer and reply handling.
//
// Usage: one request on the in_ channel is a payload byte, a received reply
// or a timer tick (in_req_type). Each request yields one or more results on
// the out_ channel; out_last marks the final one of a request. Frames go out up to
// two bytes per result: 0x20, id, length, payload, complemented 8-bit sum;
// the FIN frame is 0x10, 0, sum. cfg_wr_en / cfg_wr_data load the timeout in
// ticks (reset value 20). Timing: a request that causes no frame passes
// through S_PUSH into the output register. A frame of L payload bytes has
// L+4 bytes, walked byte by byte through S_FETCH and S_BYTE by a single 8-bit
// checksum adder and one store read port, with an S_PUSH step per result; the
// next request can be taken once the final result is in the output register.
// in_ready is high only while the sequencer is idle.
// Results sit in an output register; a stalled receiver holds the sequencer
// at its next result, and the next request may be taken while the final
// result of the previous one still waits.
// Reset: synchronous active-low; phase returns to collecting, the fill and wait
// counters and id clear; store contents are not cleared.
module stop_and_wait_arq_sender (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [7:0]  in_payload_byte,
  input  logic        in_last_of_file,
  input  logic [7:0]  in_rx_type,
  input  logic [7:0]  in_rx_id,
  input  logic [7:0]  in_rx_check,
  input  logic [11:0] in_rx_len,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_tx_byte_a,
  output logic [7:0]  out_tx_byte_b,
  output logic [1:0]  out_tx_count,
  output logic        out_end_of_frame,
  output logic        out_last,
  output logic [2:0]  out_status
);

  localparam int FW = sawarq_pkg::FILL_W;
  localparam int AW = sawarq_pkg::ADDR_W;
  localparam int IW = sawarq_pkg::IDX_W;

  logic [7:0] store_mem [sawarq_pkg::PACKET_BYTES];
  logic [7:0] rdata_r;

  sawarq_pkg::seq_state_t state_r, state_nxt;
  sawarq_pkg::phase_t     phase_r, phase_nxt;

  logic [FW-1:0] fill_r, fill_nxt;
  logic [7:0]    seq_r, seq_nxt;
  logic [7:0]    wait_r, wait_nxt;
  logic          final_r, final_nxt;
  logic [7:0]    timeout_r;

  logic [IW-1:0] idx_r, idx_nxt;
  logic [IW-1:0] n_r, n_nxt;
  logic          half_r, half_nxt;
  logic [7:0]    sum_r, sum_nxt;
  logic [7:0]    hdr0_r, hdr0_nxt;
  logic [7:0]    hdr1_r, hdr1_nxt;
  logic [FW-1:0] len_r, len_nxt;

  logic [7:0] pa_r, pa_nxt;
  logic [7:0] pb_r, pb_nxt;
  logic [1:0] pcnt_r, pcnt_nxt;
  logic       peof_r, peof_nxt;
  logic       plast_r, plast_nxt;
  logic [2:0] pst_r, pst_nxt;

  logic       ov_r, ov_nxt;
  logic [7:0] oa_r, ob_r;
  logic [1:0] ocnt_r;
  logic       oeof_r, olast_r;
  logic [2:0] ost_r;

  logic          accept;
  logic          wr_en;
  logic [AW-1:0] rd_addr;
  logic [IW-1:0] pay_idx;
  logic [7:0]    fbyte;
  logic [7:0]    ack_sum;
  logic          ack_good;
  logic [7:0]    tick_w;
  logic [FW-1:0] fill_inc;
  logic          slot_free;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == sawarq_pkg::S_IDLE);
  assign slot_free = !ov_r || out_ready;
  assign fill_inc  = fill_r + FW'(1);
  assign ack_sum   = in_rx_type + in_rx_id;
  assign ack_good  = (in_rx_len == sawarq_pkg::ACK_LEN) && (~ack_sum == in_rx_check)
                     && (in_rx_id == seq_r);
  assign tick_w    = (wait_r == 8'hFF) ? wait_r : wait_r + 8'd1;
  assign wr_en     = accept && (in_req_type == sawarq_pkg::REQ_BYTE)
                     && (phase_r == sawarq_pkg::PH_COLLECT)
                     && (fill_r < FW'(sawarq_pkg::PACKET_BYTES));
  assign pay_idx   = idx_r - IW'(3);
  assign rd_addr   = pay_idx[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[fill_r[AW-1:0]] <= in_payload_byte;
    end
    rdata_r <= store_mem[rd_addr];
  end

  always_comb begin
    if (idx_r == n_r) begin
      fbyte = ~sum_r;
    end else if (idx_r == IW'(0)) begin
      fbyte = hdr0_r;
    end else if (idx_r == IW'(1)) begin
      fbyte = hdr1_r;
    end else if (idx_r == IW'(2)) begin
      fbyte = 8'(len_r);
    end else begin
      fbyte = rdata_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    fill_nxt  = fill_r;
    seq_nxt   = seq_r;
    wait_nxt  = wait_r;
    final_nxt = final_r;
    idx_nxt   = idx_r;
    n_nxt     = n_r;
    half_nxt  = half_r;
    sum_nxt   = sum_r;
    hdr0_nxt  = hdr0_r;
    hdr1_nxt  = hdr1_r;
    len_nxt   = len_r;
    pa_nxt    = pa_r;
    pb_nxt    = pb_r;
    pcnt_nxt  = pcnt_r;
    peof_nxt  = peof_r;
    plast_nxt = plast_r;
    pst_nxt   = pst_r;
    ov_nxt    = ov_r && !out_ready;

    case (state_r)
      sawarq_pkg::S_IDLE: begin
        if (accept) begin
          // default: single result without frame bytes
          pa_nxt    = 8'd0;
          pb_nxt    = 8'd0;
          pcnt_nxt  = 2'd0;
          peof_nxt  = 1'b0;
          plast_nxt = 1'b1;
          pst_nxt   = sawarq_pkg::ST_ACCEPTED;
          state_nxt = sawarq_pkg::S_PUSH;
          idx_nxt   = '0;
          half_nxt  = 1'b0;
          sum_nxt   = 8'd0;
          hdr0_nxt  = sawarq_pkg::T_SEND;
          hdr1_nxt  = seq_r;
          len_nxt   = fill_r;
          n_nxt     = IW'(fill_r) + IW'(3);
          case (in_req_type)
            sawarq_pkg::REQ_BYTE: begin
              if (!wr_en) begin
                pst_nxt = sawarq_pkg::ST_REJECTED;
              end else begin
                fill_nxt = fill_inc;
                if (fill_inc >= FW'(sawarq_pkg::PACKET_BYTES) || in_last_of_file) begin
                  final_nxt = in_last_of_file;
                  phase_nxt = sawarq_pkg::PH_WAIT;
                  wait_nxt  = 8'd0;
                  len_nxt   = fill_inc;
                  n_nxt     = IW'(fill_inc) + IW'(3);
                  pst_nxt   = sawarq_pkg::ST_SENT;
                  state_nxt = sawarq_pkg::S_FETCH;
                end
              end
            end
            sawarq_pkg::REQ_REPLY: begin
              if (phase_r != sawarq_pkg::PH_WAIT) begin
                pst_nxt = sawarq_pkg::ST_REJECTED;
              end else if (in_rx_type == sawarq_pkg::T_ACK && ack_good) begin
                seq_nxt  = seq_r + 8'd1;
                fill_nxt = '0;
                wait_nxt = 8'd0;
                if (final_r) begin
                  final_nxt = 1'b0;
                  phase_nxt = sawarq_pkg::PH_DONE;
                  hdr0_nxt  = sawarq_pkg::T_FIN;
                  hdr1_nxt  = 8'd0;
                  n_nxt     = IW'(2);
                  pst_nxt   = sawarq_pkg::ST_FIN;
                  state_nxt = sawarq_pkg::S_FETCH;
                end else begin
                  phase_nxt = sawarq_pkg::PH_COLLECT;
                end
              end else if (in_rx_type == sawarq_pkg::T_ACK
                           || in_rx_type == sawarq_pkg::T_AGAIN) begin
                wait_nxt  = 8'd0;
                pst_nxt   = sawarq_pkg::ST_NACK;
                state_nxt = sawarq_pkg::S_FETCH;
              end else begin
                wait_nxt = 8'd0;
              end
            end
            sawarq_pkg::REQ_TICK: begin
              if (phase_r == sawarq_pkg::PH_WAIT) begin
                wait_nxt = tick_w;
                if (tick_w >= timeout_r) begin
                  wait_nxt  = 8'd0;
                  pst_nxt   = sawarq_pkg::ST_TIMEOUT;
                  state_nxt = sawarq_pkg::S_FETCH;
                end
              end
            end
            default: begin
              pst_nxt = sawarq_pkg::ST_REJECTED;
            end
          endcase
        end
      end
      sawarq_pkg::S_FETCH: begin
        state_nxt = sawarq_pkg::S_BYTE;
      end
      sawarq_pkg::S_BYTE: begin
        sum_nxt = sum_r + fbyte;
        if (!half_r) begin
          pa_nxt = fbyte;
          pb_nxt = 8'd0;
          if (idx_r == n_r) begin
            pcnt_nxt  = 2'd1;
            peof_nxt  = 1'b1;
            plast_nxt = 1'b1;
            state_nxt = sawarq_pkg::S_PUSH;
          end else begin
            half_nxt  = 1'b1;
            idx_nxt   = idx_r + IW'(1);
            state_nxt = sawarq_pkg::S_FETCH;
          end
        end else begin
          pb_nxt    = fbyte;
          pcnt_nxt  = 2'd2;
          peof_nxt  = (idx_r == n_r);
          plast_nxt = (idx_r == n_r);
          state_nxt = sawarq_pkg::S_PUSH;
        end
      end
      sawarq_pkg::S_PUSH: begin
        if (slot_free) begin
          ov_nxt = 1'b1;
          if (plast_r) begin
            state_nxt = sawarq_pkg::S_IDLE;
          end else begin
            half_nxt  = 1'b0;
            idx_nxt   = idx_r + IW'(1);
            state_nxt = sawarq_pkg::S_FETCH;
          end
        end
      end
      default: begin
        state_nxt = sawarq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= sawarq_pkg::S_IDLE;
      phase_r   <= sawarq_pkg::PH_COLLECT;
      fill_r    <= '0;
      seq_r     <= 8'd0;
      wait_r    <= 8'd0;
      final_r   <= 1'b0;
      timeout_r <= sawarq_pkg::TIMEOUT_RST;
      ov_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      fill_r  <= fill_nxt;
      seq_r   <= seq_nxt;
      wait_r  <= wait_nxt;
      final_r <= final_nxt;
      ov_r    <= ov_nxt;
      if (cfg_wr_en) begin
        timeout_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    n_r     <= n_nxt;
    half_r  <= half_nxt;
    sum_r   <= sum_nxt;
    hdr0_r  <= hdr0_nxt;
    hdr1_r  <= hdr1_nxt;
    len_r   <= len_nxt;
    pa_r    <= pa_nxt;
    pb_r    <= pb_nxt;
    pcnt_r  <= pcnt_nxt;
    peof_r  <= peof_nxt;
    plast_r <= plast_nxt;
    pst_r   <= pst_nxt;
    if (state_r == sawarq_pkg::S_PUSH && slot_free) begin
      oa_r    <= pa_r;
      ob_r    <= pb_r;
      ocnt_r  <= pcnt_r;
      oeof_r  <= peof_r;
      olast_r <= plast_r;
      ost_r   <= pst_r;
    end
  end

  assign out_valid        = ov_r;
  assign out_tx_byte_a    = oa_r;
  assign out_tx_byte_b    = ob_r;
  assign out_tx_count     = ocnt_r;
  assign out_end_of_frame = oeof_r;
  assign out_last         = olast_r;
  assign out_status       = ost_r;

endmodule
